@@ hw/rtl/atpf_pkg.sv @@
// Shared types and constants for the affine tile pixel fetch block.
// No dependencies; imported by the queue, front end, back end and top level of the block.
package atpf_pkg;

   localparam int STORE_WORDS = 16384;
   localparam int STORE_AW    = $clog2(STORE_WORDS);
   localparam int DATA_W      = 16;
   localparam int MAP_COORD_W = 7;   // 128 tiles per map row
   localparam int PIX_SEL_W   = 6;   // 3 bits of y, 3 bits of x inside a character
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 26;
   localparam int SUM_W       = 30;  // holds the widest sum of the five terms

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATRIX_A       = 3'd0,
      CSR_MATRIX_B       = 3'd1,
      CSR_MATRIX_C       = 3'd2,
      CSR_MATRIX_D       = 3'd3,
      CSR_CENTER_X       = 3'd4,
      CSR_CENTER_Y       = 3'd5,
      CSR_SCROLL_OFFSETS = 3'd6,
      CSR_MODE_CONTROL   = 3'd7
   } csr_index_type;

   localparam logic [1:0] REPEAT_TRANSPARENT = 2'd2;
   localparam logic [1:0] REPEAT_TILE0       = 2'd3;

   // One queued transaction: either a store write or a prepared fetch
   typedef struct packed {
      logic                  is_write;
      logic [STORE_AW-1:0]   addr;     // write address, or tile map address
      logic [DATA_W-1:0]     data;
      logic [PIX_SEL_W-1:0]  pix_sel;
      logic                  blank;    // transparent outside the plane
      logic                  tile0;    // character 0 outside the plane
      logic                  ext;      // extended background layer
   } atpf_entry_type;

endpackage

@@ hw/rtl/atpf_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module atpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_a_en,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic                     rd_b_en,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // reads return the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_a_en) rd_a_ff <= mem_ff[rd_a_addr];
      if (rd_b_en) rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ hw/rtl/atpf_fifo.sv @@
// Short queue between the address front end and the store back end.
// Depends on atpf_pkg for the entry type.
module atpf_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  atpf_pkg::atpf_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     valid,
   output atpf_pkg::atpf_entry_type pop_entry
);
   import atpf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   atpf_entry_type entries_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign valid     = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

@@ hw/rtl/atpf_front.sv @@
// Front end: configuration registers, transaction intake and the affine
// address pipeline. Depends on atpf_pkg; feeds atpf_fifo.
module atpf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [atpf_pkg::STORE_AW-1:0]     req_store_address,
   input  logic [atpf_pkg::DATA_W-1:0]       req_store_data,
   input  logic [7:0]                        req_column,
   input  logic [7:0]                        req_row,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [atpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [atpf_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                              push,
   output atpf_pkg::atpf_entry_type          push_entry,
   input  logic                              queue_full
);
   import atpf_pkg::*;

   localparam int PX_W = SUM_W - 8;

   // configuration
   logic signed [15:0] matrix_a_ff, matrix_b_ff, matrix_c_ff, matrix_d_ff;
   logic signed [12:0] center_x_ff, center_y_ff;
   logic [25:0]        scroll_ff;
   logic [2:0]         mode_ff;

   // stage 1: accepted transaction
   logic                r1_v_ff, r1_v_in;
   logic                r1_action_ff;
   logic [STORE_AW-1:0] r1_addr_ff;
   logic [DATA_W-1:0]   r1_data_ff;
   logic [7:0]          r1_col_ff, r1_row_ff;

   // stage 2: partial products
   logic                r2_v_ff, r2_v_in;
   logic                r2_action_ff;
   logic [STORE_AW-1:0] r2_addr_ff;
   logic [DATA_W-1:0]   r2_data_ff;
   logic signed [26:0]  ah_ff, bv_ff, ch_ff, dv_ff;
   logic signed [24:0]  br_ff, acol_ff, dr_ff, ccol_ff;

   logic                adv;
   logic signed [12:0]  hofs, vofs;
   logic signed [13:0]  hdiff, vdiff;
   logic signed [10:0]  hc, vc;
   logic signed [8:0]   col_s, row_s;
   logic signed [26:0]  ah_in, bv_in, ch_in, dv_in;
   logic signed [24:0]  br_in, acol_in, dr_in, ccol_in;

   logic signed [26:0]  ah_fl, bv_fl, ch_fl, dv_fl;
   logic signed [24:0]  br_fl, dr_fl;
   logic signed [20:0]  cx_sh, cy_sh;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic [PX_W-1:0]     px, py;
   logic                outside;

   assign csr_ready = 1'b1;
   assign adv       = !r2_v_ff || !queue_full;
   assign req_ready = adv;
   assign push      = r2_v_ff && !queue_full;

   assign r1_v_in = adv ? req_valid : r1_v_ff;
   assign r2_v_in = adv ? r1_v_ff : r2_v_ff;

   // scroll minus centre, clipped to 10 bits plus sign
   assign hofs  = scroll_ff[12:0];
   assign vofs  = scroll_ff[25:13];
   assign hdiff = 14'(hofs) - 14'(center_x_ff);
   assign vdiff = 14'(vofs) - 14'(center_y_ff);
   assign hc    = {hdiff[13], hdiff[9:0]};
   assign vc    = {vdiff[13], vdiff[9:0]};
   assign col_s = {1'b0, r1_col_ff};
   assign row_s = {1'b0, r1_row_ff};

   assign ah_in   = 27'(matrix_a_ff) * 27'(hc);
   assign bv_in   = 27'(matrix_b_ff) * 27'(vc);
   assign br_in   = 25'(matrix_b_ff) * 25'(row_s);
   assign acol_in = 25'(matrix_a_ff) * 25'(col_s);
   assign ch_in   = 27'(matrix_c_ff) * 27'(hc);
   assign dv_in   = 27'(matrix_d_ff) * 27'(vc);
   assign dr_in   = 25'(matrix_d_ff) * 25'(row_s);
   assign ccol_in = 25'(matrix_c_ff) * 25'(col_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_a_ff <= '0;
         matrix_b_ff <= '0;
         matrix_c_ff <= '0;
         matrix_d_ff <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         scroll_ff   <= '0;
         mode_ff     <= '0;
         r1_v_ff     <= 1'b0;
         r2_v_ff     <= 1'b0;
      end else begin
         r1_v_ff <= r1_v_in;
         r2_v_ff <= r2_v_in;
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_MATRIX_A:       matrix_a_ff <= csr_data[15:0];
               CSR_MATRIX_B:       matrix_b_ff <= csr_data[15:0];
               CSR_MATRIX_C:       matrix_c_ff <= csr_data[15:0];
               CSR_MATRIX_D:       matrix_d_ff <= csr_data[15:0];
               CSR_CENTER_X:       center_x_ff <= csr_data[12:0];
               CSR_CENTER_Y:       center_y_ff <= csr_data[12:0];
               CSR_SCROLL_OFFSETS: scroll_ff   <= csr_data;
               CSR_MODE_CONTROL:   mode_ff     <= csr_data[2:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_action_ff <= req_action;
         r1_addr_ff   <= req_store_address;
         r1_data_ff   <= req_store_data;
         r1_col_ff    <= req_column;
         r1_row_ff    <= req_row;
         r2_action_ff <= r1_action_ff;
         r2_addr_ff   <= r1_addr_ff;
         r2_data_ff   <= r1_data_ff;
         ah_ff        <= ah_in;
         bv_ff        <= bv_in;
         br_ff        <= br_in;
         acol_ff      <= acol_in;
         ch_ff        <= ch_in;
         dv_ff        <= dv_in;
         dr_ff        <= dr_in;
         ccol_ff      <= ccol_in;
      end
   end

   // partial products floored to multiples of 64; column term kept whole
   assign ah_fl = {ah_ff[26:6], 6'd0};
   assign bv_fl = {bv_ff[26:6], 6'd0};
   assign br_fl = {br_ff[24:6], 6'd0};
   assign ch_fl = {ch_ff[26:6], 6'd0};
   assign dv_fl = {dv_ff[26:6], 6'd0};
   assign dr_fl = {dr_ff[24:6], 6'd0};
   assign cx_sh = {center_x_ff, 8'd0};
   assign cy_sh = {center_y_ff, 8'd0};

   assign sum_x = SUM_W'(ah_fl) + SUM_W'(bv_fl) + SUM_W'(br_fl) + SUM_W'(cx_sh)
                + SUM_W'(acol_ff);
   assign sum_y = SUM_W'(ch_fl) + SUM_W'(dv_fl) + SUM_W'(dr_fl) + SUM_W'(cy_sh)
                + SUM_W'(ccol_ff);
   assign px    = sum_x[SUM_W-1:8];
   assign py    = sum_y[SUM_W-1:8];
   assign outside = (px[PX_W-1:10] != '0) || (py[PX_W-1:10] != '0);

   always_comb begin
      push_entry          = '0;
      push_entry.is_write = !r2_action_ff;
      push_entry.data     = r2_data_ff;
      push_entry.pix_sel  = {py[2:0], px[2:0]};
      push_entry.ext      = mode_ff[2];
      push_entry.blank    = (mode_ff[1:0] == REPEAT_TRANSPARENT) && outside;
      push_entry.tile0    = (mode_ff[1:0] == REPEAT_TILE0) && outside;
      if (r2_action_ff) begin
         push_entry.addr = {py[9:3], px[9:3]};
      end else begin
         push_entry.addr = r2_addr_ff;
      end
   end

endmodule

@@ hw/rtl/atpf_back.sv @@
// Back end: store writes, tile map read, character pixel read and the
// result register. Depends on atpf_pkg and atpf_ram.
module atpf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     entry_valid,
   input  atpf_pkg::atpf_entry_type entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_color_index,
   output logic                     rsp_high_priority,
   output logic                     rsp_transparent
);
   import atpf_pkg::*;

   logic                 adv;
   logic [DATA_W-1:0]    map_word, char_word;
   logic [STORE_AW-1:0]  char_addr;
   logic [7:0]           tile;

   logic                 s1_v_ff, s1_v_in;
   logic [PIX_SEL_W-1:0] s1_pix_sel_ff;
   logic                 s1_blank_ff, s1_tile0_ff, s1_ext_ff;
   logic                 s2_v_ff, s2_v_in;
   logic                 s2_blank_ff, s2_ext_ff;
   logic                 out_v_ff, out_v_in;
   logic [7:0]           color_ff, color_in;
   logic                 pri_ff, pri_in;
   logic [7:0]           pix;

   // the whole back end moves together whenever the result register is free
   assign adv      = !out_v_ff || rsp_ready;
   assign pop      = adv && entry_valid;
   assign s1_v_in  = adv ? (pop && !entry.is_write) : s1_v_ff;
   assign s2_v_in  = adv ? s1_v_ff : s2_v_ff;
   assign out_v_in = adv ? s2_v_ff : out_v_ff;

   assign tile      = s1_tile0_ff ? 8'd0 : map_word[7:0];
   assign char_addr = {tile, s1_pix_sel_ff};

   atpf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock     (clock),
      .wr_en     (pop && entry.is_write),
      .wr_addr   (entry.addr),
      .wr_data   (entry.data),
      .rd_a_en   (adv),
      .rd_a_addr (entry.addr),
      .rd_a_data (map_word),
      .rd_b_en   (adv),
      .rd_b_addr (char_addr),
      .rd_b_data (char_word)
   );

   always_comb begin
      pix = s2_blank_ff ? 8'd0 : char_word[15:8];
      if (s2_ext_ff) begin
         pri_in   = pix[7];
         color_in = {1'b0, pix[6:0]};
      end else begin
         pri_in   = 1'b0;
         color_in = pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pix_sel_ff <= entry.pix_sel;
         s1_blank_ff   <= entry.blank;
         s1_tile0_ff   <= entry.tile0;
         s1_ext_ff     <= entry.ext;
         s2_blank_ff   <= s1_blank_ff;
         s2_ext_ff     <= s1_ext_ff;
         color_ff      <= color_in;
         pri_ff        <= pri_in;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_color_index   = color_ff;
   assign rsp_high_priority = pri_ff;
   assign rsp_transparent   = (color_ff == 8'd0);

endmodule

@@ hw/rtl/affine_tile_pixel_fetch.sv @@
// Top level of the affine tile pixel fetch block.
// Depends on atpf_pkg, atpf_front, atpf_fifo and atpf_back.

// When the result side does not stall, the block takes one transaction per clock
// cycle, store write or pixel fetch, and returns one result per cycle for fetches;
// writes return nothing. After the request is accepted, a fetch passes in turn
// through the partial products, the sums written into the queue, the tile map
// read, the dependent character pixel read (the two reads use the two read ports
// of the 16K-word store) and the result register. The queue between the arithmetic
// and the store lets either side stall alone. The store powers up with undefined
// contents and needs no clearing; fetches must only touch written words.
// Configuration writes are always ready and take effect at once.
module affine_tile_pixel_fetch #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [atpf_pkg::STORE_AW-1:0]     req_store_address,
   input  logic [atpf_pkg::DATA_W-1:0]       req_store_data,
   input  logic [7:0]                        req_column,
   input  logic [7:0]                        req_row,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_color_index,
   output logic                              rsp_high_priority,
   output logic                              rsp_transparent,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [atpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [atpf_pkg::CSR_DATA_W-1:0]   csr_data
);
   import atpf_pkg::*;

   logic           push, queue_full, pop, queue_valid;
   atpf_entry_type push_entry, pop_entry;

   atpf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_store_address (req_store_address),
      .req_store_data    (req_store_data),
      .req_column        (req_column),
      .req_row           (req_row),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .push              (push),
      .push_entry        (push_entry),
      .queue_full        (queue_full)
   );

   atpf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .valid      (queue_valid),
      .pop_entry  (pop_entry)
   );

   atpf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .entry_valid       (queue_valid),
      .entry             (pop_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_color_index   (rsp_color_index),
      .rsp_high_priority (rsp_high_priority),
      .rsp_transparent   (rsp_transparent)
   );

endmodule

@@ hw/rtl/atpf_checker.sv @@
// Port-level checks for affine_tile_pixel_fetch, attached by bind.
// Needs only the clock, reset and result-side port names of the top level.
module atpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_color_index,
   input logic       rsp_high_priority,
   input logic       rsp_transparent
);

   // no result may be pending straight after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color_index)
         && $stable(rsp_high_priority) && $stable(rsp_transparent))
      else $error("result changed while stalled");

   a_transparent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_transparent == (rsp_color_index == 8'd0))
      else $error("transparent flag disagrees with colour index");

   // priority is only split off in extended mode, which leaves 7 index bits
   a_priority_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_high_priority |-> !rsp_color_index[7])
      else $error("high priority with an 8-bit colour index");

endmodule

bind affine_tile_pixel_fetch atpf_checker u_checker (.*);

@@ test/tb_affine_tile_pixel_fetch.sv @@
// Self-checking testbench for the affine tile pixel fetch block.
// Needs atpf_pkg and the affine_tile_pixel_fetch RTL; nothing else.
// A local model of the matrix, clip and store lookups predicts every fetch result.
`timescale 1ns / 1ps

module tb_affine_tile_pixel_fetch;
   import atpf_pkg::*;

   localparam logic       ACTION_WRITE    = 1'b0;
   localparam logic       ACTION_FETCH    = 1'b1;
   localparam logic [1:0] REPEAT_WRAP     = 2'd0;
   localparam logic [1:0] REPEAT_WRAP_ALT = 2'd1;
   localparam logic       EXT_OFF         = 1'b0;
   localparam logic       EXT_ON          = 1'b1;
   localparam logic [15:0] IDENTITY       = 16'h0100;   // 1.0 in 8.8
   localparam longint     FLOOR64_MASK    = -64;
   localparam longint     PLANE_MAX       = 1023;
   localparam int         SETTLE_CYCLES   = 12;
   localparam int         RSP_HOLD_CYCLES = 300;
   localparam int         RANDOM_PHASES   = 12;
   localparam int         PHASE_ITEMS     = 120;
   localparam int         FILL_WORDS      = 128;
   localparam int         MAX_REPORTS     = 60;
   localparam int         WATCHDOG_NS     = 5_000_000;

   typedef struct {
      logic                action;
      logic [STORE_AW-1:0] store_address;
      logic [DATA_W-1:0]   store_data;
      logic [7:0]          column;
      logic [7:0]          row;
   } pixel_req_type;

   typedef struct {
      logic [7:0] color_index;
      logic       high_priority;
      logic       transparent;
   } pixel_rsp_type;

   typedef struct {
      logic [15:0] a, b, c, d;
      logic [12:0] cx, cy;
      logic [25:0] scroll;
      logic [2:0]  mode;
   } affine_cfg_type;

   logic                  clock;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic                  req_action        = ACTION_WRITE;
   logic [STORE_AW-1:0]   req_store_address = '0;
   logic [DATA_W-1:0]     req_store_data    = '0;
   logic [7:0]            req_column        = '0;
   logic [7:0]            req_row           = '0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic [7:0]            rsp_color_index;
   logic                  rsp_high_priority;
   logic                  rsp_transparent;
   logic                  csr_valid         = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index         = CSR_MATRIX_A;
   logic [CSR_DATA_W-1:0] csr_data          = '0;

   affine_cfg_type   cfg = '{default: '0};
   logic [DATA_W-1:0] store_mirror [STORE_WORDS];
   bit               store_written [STORE_WORDS];
   pixel_rsp_type    expected_pixels [$];
   int               errors        = 0;
   int               items_sent    = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int unsigned      hold_token    = 0;

   affine_tile_pixel_fetch u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_store_address (req_store_address),
      .req_store_data    (req_store_data),
      .req_column        (req_column),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_color_index   (rsp_color_index),
      .rsp_high_priority (rsp_high_priority),
      .rsp_transparent   (rsp_transparent),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("Verification failed");
      $finish;
   end

   // ---------------- prediction ----------------

   // scroll minus centre, kept to 10 bits plus sign
   function automatic longint clip_offset(longint h);
      longint low;
      low = h & 64'sd1023;
      return h[13] ? low - 1024 : low;
   endfunction

   function automatic void source_xy(input logic [7:0] column, input logic [7:0] row,
                                     output longint px, output longint py);
      longint a, b, c, d, cx, cy, hofs, vofs, hc, vc, col, rw, sx, sy;
      a    = $signed(cfg.a);
      b    = $signed(cfg.b);
      c    = $signed(cfg.c);
      d    = $signed(cfg.d);
      cx   = $signed(cfg.cx);
      cy   = $signed(cfg.cy);
      hofs = $signed(cfg.scroll[12:0]);
      vofs = $signed(cfg.scroll[25:13]);
      col  = column;
      rw   = row;
      hc   = clip_offset(hofs - cx);
      vc   = clip_offset(vofs - cy);
      sx = ((a * hc) & FLOOR64_MASK) + ((b * vc) & FLOOR64_MASK) + ((b * rw) & FLOOR64_MASK)
         + cx * 256 + a * col;
      sy = ((c * hc) & FLOOR64_MASK) + ((d * vc) & FLOOR64_MASK) + ((d * rw) & FLOOR64_MASK)
         + cy * 256 + c * col;
      px = sx >>> 8;
      py = sy >>> 8;
   endfunction

   function automatic pixel_rsp_type fetch_pixel(logic [7:0] column, logic [7:0] row);
      longint        px, py;
      logic          outside;
      logic [7:0]    tile, pix;
      pixel_rsp_type r;
      source_xy(column, row, px, py);
      outside = (px < 0) || (px > PLANE_MAX) || (py < 0) || (py > PLANE_MAX);
      if (cfg.mode[1:0] == REPEAT_TRANSPARENT && outside) begin
         pix = 8'h00;
      end else begin
         if (cfg.mode[1:0] == REPEAT_TILE0 && outside) begin
            tile = 8'h00;
         end else begin
            tile = store_mirror[{py[9:3], px[9:3]}][7:0];
         end
         pix = store_mirror[{tile, py[2:0], px[2:0]}][15:8];
      end
      r.high_priority = 1'b0;
      if (cfg.mode[2]) begin
         r.high_priority = pix[7];
         pix[7] = 1'b0;
      end
      r.color_index = pix;
      r.transparent = (pix == 8'h00);
      return r;
   endfunction

   // ---------------- result side ----------------

   // receiver; a new hold_token starts one long hold-off
   always @(posedge clock) begin : rsp_drive
      int unsigned hold_seen;
      int          hold_left;
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         if (errors < MAX_REPORTS) begin
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
         end
         errors++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      pixel_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            if (errors < MAX_REPORTS) begin
               $display("%0t: result transaction with no fetch outstanding, colour index %0d",
                        $time, rsp_color_index);
            end
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("colour index", want.color_index, rsp_color_index);
            check_field("high priority", 8'(want.high_priority), 8'(rsp_high_priority));
            check_field("transparent", 8'(want.transparent), 8'(rsp_transparent));
         end
      end
   end

   // ---------------- request side ----------------

   task automatic send_item(pixel_req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= item.action;
      req_store_address <= item.store_address;
      req_store_data    <= item.store_data;
      req_column        <= item.column;
      req_row           <= item.row;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      items_sent++;
      if (item.action == ACTION_WRITE) begin
         store_mirror[item.store_address]  = item.store_data;
         store_written[item.store_address] = 1'b1;
      end else begin
         expected_pixels.push_back(fetch_pixel(item.column, item.row));
      end
   endtask

   task automatic send_write(logic [STORE_AW-1:0] address, logic [DATA_W-1:0] word);
      pixel_req_type item;
      item.action        = ACTION_WRITE;
      item.store_address = address;
      item.store_data    = word;
      item.column        = 8'($urandom);   // ignored on a write
      item.row           = 8'($urandom);
      send_item(item);
   endtask

   // a word a fetch is about to read gets written first if it never was
   task automatic ensure_written(logic [STORE_AW-1:0] address);
      if (!store_written[address]) begin
         send_write(address, pick_word());
      end
   endtask

   task automatic send_fetch(logic [7:0] column, logic [7:0] row);
      pixel_req_type item;
      longint        px, py;
      logic          outside;
      logic [7:0]    tile;
      source_xy(column, row, px, py);
      outside = (px < 0) || (px > PLANE_MAX) || (py < 0) || (py > PLANE_MAX);
      if (!(cfg.mode[1:0] == REPEAT_TRANSPARENT && outside)) begin
         if (cfg.mode[1:0] == REPEAT_TILE0 && outside) begin
            tile = 8'h00;
         end else begin
            ensure_written({py[9:3], px[9:3]});
            tile = store_mirror[{py[9:3], px[9:3]}][7:0];
         end
         ensure_written({tile, py[2:0], px[2:0]});
      end
      item.action        = ACTION_FETCH;
      item.store_address = STORE_AW'($urandom);
      item.store_data    = DATA_W'($urandom);
      item.column        = column;
      item.row           = row;
      send_item(item);
   endtask

   // stop offering, let every result come home, then let the pipeline empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d,
                             logic [12:0] cx, logic [12:0] cy, logic [25:0] scroll,
                             logic [2:0] mode);
      csr_index_type         idx;
      logic [CSR_DATA_W-1:0] data;
      wait_drained();
      idx = idx.first();
      do begin
         data = CSR_DATA_W'($urandom);   // bits above the register width are noise
         case (idx)
            CSR_MATRIX_A:       data[15:0] = a;
            CSR_MATRIX_B:       data[15:0] = b;
            CSR_MATRIX_C:       data[15:0] = c;
            CSR_MATRIX_D:       data[15:0] = d;
            CSR_CENTER_X:       data[12:0] = cx;
            CSR_CENTER_Y:       data[12:0] = cy;
            CSR_SCROLL_OFFSETS: data       = scroll;
            CSR_MODE_CONTROL:   data[2:0]  = mode;
            default:            ;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= data;
         @(posedge clock);
         while (csr_ready !== 1'b1) @(posedge clock);
         idx = idx.next();
      end while (idx != idx.first());
      csr_valid <= 1'b0;
      @(posedge clock);
      cfg = '{a: a, b: b, c: c, d: d, cx: cx, cy: cy, scroll: scroll, mode: mode};
   endtask

   // ---------------- random value pickers ----------------

   function automatic logic [15:0] pick_word();
      logic [15:0] w;
      w = 16'($urandom);
      if ($urandom_range(7) == 0) w[15:8] = 8'h00;   // keep transparent pixels common
      return w;
   endfunction

   function automatic logic [15:0] pick_matrix();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return IDENTITY;
         4, 5:    return 16'($urandom);
         default: return 16'($urandom_range(1023) - 512);
      endcase
   endfunction

   function automatic logic [12:0] pick_center();
      case ($urandom_range(3))
         0:       return ($urandom_range(1) != 0) ? 13'h1000 : 13'h0fff;
         1:       return 13'($urandom);
         default: return 13'($urandom_range(383) - 128);
      endcase
   endfunction

   function automatic logic [25:0] pick_scroll();
      case ($urandom_range(3))
         0: return 26'($urandom);
         1: return {13'($urandom_range(127) - 64), 13'($urandom_range(127) - 64)};
         2: begin
            case ($urandom_range(2))
               0:       return 26'h3ffffff;
               1:       return {13'h1000, 13'h0fff};
               default: return {13'h0fff, 13'h1000};
            endcase
         end
         default: return {13'($urandom_range(255)), 13'($urandom_range(255))};
      endcase
   endfunction

   // ---------------- tests ----------------

   // plain run of writes over character 0 and the first map entries
   task automatic test_store_fill();
      send_idle_pct = 28;
      recv_idle_pct = 84;
      for (int addr = 0; addr < FILL_WORDS; addr++) begin
         send_write(STORE_AW'(addr), pick_word());
      end
   endtask

   task automatic test_directed();
      set_config(IDENTITY, 16'h0000, 16'h0000, IDENTITY, 13'h0000, 13'h0000, 26'h0,
                 {EXT_OFF, REPEAT_WRAP});
      send_fetch(8'd0, 8'd0);
      send_fetch(8'd255, 8'd0);
      send_fetch(8'd0, 8'd255);
      send_fetch(8'd255, 8'd255);
      // map entry 0 then its character pixel, each read straight after the write
      send_write(14'h0000, 16'hA53C);
      send_fetch(8'd0, 8'd0);
      send_write(14'h0F00, 16'h0000);
      send_fetch(8'd0, 8'd0);
      set_config(IDENTITY, 16'h0000, 16'h0000, IDENTITY, 13'h0000, 13'h0000, 26'h0,
                 {EXT_ON, REPEAT_WRAP});
      send_write(14'h0F00, 16'hFF00);
      send_fetch(8'd0, 8'd0);
      // horizontal scroll at its most negative puts the screen left of the plane
      set_config(IDENTITY, 16'h0000, 16'h0000, IDENTITY, 13'h0000, 13'h0000,
                 {13'h0000, 13'h1000}, {EXT_OFF, REPEAT_TRANSPARENT});
      send_fetch(8'd10, 8'd10);
      send_fetch(8'd255, 8'd255);
      set_config(IDENTITY, 16'h0000, 16'h0000, IDENTITY, 13'h0000, 13'h0000,
                 {13'h0000, 13'h1000}, {EXT_OFF, REPEAT_TILE0});
      send_fetch(8'd10, 8'd10);
      send_fetch(8'd3, 8'd250);
      set_config(IDENTITY, 16'h0000, 16'h0000, IDENTITY, 13'h0000, 13'h0000,
                 {13'h0000, 13'h1000}, {EXT_OFF, REPEAT_WRAP_ALT});
      send_fetch(8'd10, 8'd10);
      set_config(IDENTITY, 16'h0000, 16'h0000, IDENTITY, 13'h0000, 13'h0000,
                 {13'h0000, 13'h1000}, {EXT_ON, REPEAT_TILE0});
      send_fetch(8'd0, 8'd0);
      // matrix, centre and scroll at their limits; clip sees both signs
      set_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 13'h0fff, 13'h1000, 26'h3ffffff,
                 {EXT_OFF, REPEAT_WRAP});
      send_fetch(8'd255, 8'd255);
      send_fetch(8'd0, 8'd0);
      set_config(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 13'h1000, 13'h0fff,
                 {13'h0000, 13'h0fff}, {EXT_ON, REPEAT_TRANSPARENT});
      send_fetch(8'd255, 8'd255);
      send_fetch(8'd128, 8'd1);
   endtask

   task automatic test_random_traffic();
      int         phase_start;
      int         pick;
      logic [7:0] col, row, tile;
      longint     px, py;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < RANDOM_PHASES / 3) begin
            send_idle_pct = 28;
            recv_idle_pct = 84;
         end else if (phase < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 84;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_config(pick_matrix(), pick_matrix(), pick_matrix(), pick_matrix(),
                    pick_center(), pick_center(), pick_scroll(), 3'(phase));
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            pick = int'($urandom_range(99));
            col  = 8'($urandom);
            row  = 8'($urandom);
            if (pick < 20) begin
               send_write(STORE_AW'($urandom), pick_word());
            end else if (pick < 40) begin
               // rewrite the map entry and character pixel this fetch will hit
               source_xy(col, row, px, py);
               tile = 8'($urandom);
               send_write({py[9:3], px[9:3]}, {8'($urandom), tile});
               send_write({tile, py[2:0], px[2:0]}, pick_word());
               send_fetch(col, row);
            end else begin
               send_fetch(col, row);
            end
         end
      end
   endtask

   // receiver stalls long enough for the block to fill and refuse requests
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 20;
      hold_token++;
      repeat (48) send_fetch(8'($urandom), 8'($urandom));
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_store_fill();
      test_directed();
      test_random_traffic();
      test_backpressure();
      wait_drained();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
